>>> design/mtpr_pkg.sv
// mtpr_pkg: shared types and constants for the msi-x table and pending relay
// no dependencies; used by the top level and its checker

package mtpr_pkg;

   // default number of table entries
   localparam int VECTOR_COUNT_DEF = 16;

   // receiver port: index field of a write word and size of its byte space
   localparam logic [15:0] RX_INDEX_MASK  = 16'hFFFF;
   localparam int          RX_SPACE_BYTES = 16 * 1024;
   localparam int          BUS_OFFSET_W   = $clog2(RX_SPACE_BYTES);

   // one table entry in memory: message address over message data
   localparam int ENTRY_ADDR_W = 64;
   localparam int ENTRY_DATA_W = 32;
   localparam int ENTRY_W      = ENTRY_ADDR_W + ENTRY_DATA_W;

   // operation codes of an input word
   typedef enum logic [2:0] {
      MODE_RX_WRITE  = 3'd0,
      MODE_RX_READ   = 3'd1,
      MODE_TBL_WRITE = 3'd2,
      MODE_TBL_READ  = 3'd3,
      MODE_SCAN      = 3'd4
   } mode_type;

endpackage

>>> design/mtpr_ram.sv
// mtpr_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module mtpr_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/mtpr_pick.sv
// mtpr_pick: lowest-index priority encoder over the per-vector eligible flags
// no dependencies

module mtpr_pick #(
   parameter int VECTOR_COUNT = 16
) (
   input  logic [VECTOR_COUNT-1:0]                                eligible,
   output logic                                                   found,
   output logic [(VECTOR_COUNT > 1 ? $clog2(VECTOR_COUNT) : 1)-1:0] index
);

   localparam int IdxW = VECTOR_COUNT > 1 ? $clog2(VECTOR_COUNT) : 1;

   // walk from the top down so the lowest set flag wins
   always_comb begin
      found = 1'b0;
      index = '0;
      for (int i = VECTOR_COUNT - 1; i >= 0; i--) begin
         if (eligible[i]) begin
            found = 1'b1;
            index = IdxW'(i);
         end
      end
   end

endmodule

>>> design/msix_table_pending_relay.sv
// msix_table_pending_relay: msi-x vector table, pending-bit array and message relay
// depends on mtpr_pkg, mtpr_ram and mtpr_pick

// Usage
//   A word is taken at a rising edge with start high and busy low. mode picks the
//   operation: receiver write (offset zero marks a vector pending), receiver read,
//   table write, table read, or scan for the lowest vector allowed to signal.
//   Every word gives exactly one result word, shown on the rsp_ ports for one
//   cycle with rsp_valid high, in the cycle after the accepting edge.
//   A new word is not taken while a result is shown: busy stays high for
//   the cycle in which the table memory's registered read returns.
//   Message address and data live in one memory; mask, address-nonzero, written
//   and pending flags sit in flip-flops so a scan picks its vector through a
//   priority encoder in the accepting cycle and reads that entry from memory.
//   State changes (pending set or clear, table write) take effect at the
//   accepting edge; pending_out shows the pending bits after the operation.
//   Reset clears the pending bits and all written flags at once, so every entry
//   reads as zero address, zero data and masked; no clearing pass is needed.
//   busy is high while reset is held. The receiver of results cannot stall.

module msix_table_pending_relay #(
   parameter int VECTOR_COUNT = mtpr_pkg::VECTOR_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             start,
   output logic                             busy,
   input  logic [2:0]                       req_mode,
   input  logic [mtpr_pkg::BUS_OFFSET_W-1:0] req_bus_offset,
   input  logic [31:0]                      req_write_data,
   input  logic [7:0]                       req_entry_index,
   input  logic [63:0]                      req_entry_address,
   input  logic [31:0]                      req_entry_data,
   input  logic                             req_entry_mask,
   input  logic                             req_enable_level,
   input  logic                             req_global_mask_level,
   input  logic                             req_write_ok,
   // response channel
   output logic                             rsp_valid,
   output logic [31:0]                      rsp_read_data,
   output logic                             rsp_bus_error,
   output logic [63:0]                      rsp_table_address_out,
   output logic [31:0]                      rsp_table_data_out,
   output logic                             rsp_table_mask_out,
   output logic [31:0]                      rsp_pending_out,
   output logic                             rsp_msi_issued,
   output logic [63:0]                      rsp_msi_address,
   output logic [31:0]                      rsp_msi_data,
   output logic [4:0]                       rsp_msi_vector
);

   localparam int IdxW = VECTOR_COUNT > 1 ? $clog2(VECTOR_COUNT) : 1;

   // per-vector flags and pending bits
   logic [VECTOR_COUNT-1:0] written_ff, written_in;
   logic [VECTOR_COUNT-1:0] mask_ff, mask_in;
   logic [VECTOR_COUNT-1:0] addr_nz_ff, addr_nz_in;
   logic [VECTOR_COUNT-1:0] pending_ff, pending_in;

   // response stage
   logic            stage_ff;
   logic            tbl_read_ff, tbl_read_in;
   logic            entry_valid_ff, entry_valid_in;
   logic            mask_out_ff, mask_out_in;
   logic            bus_error_ff, bus_error_in;
   logic            issued_ff, issued_in;
   logic [IdxW-1:0] vector_ff, vector_in;

   // decode
   mtpr_pkg::mode_type mode;
   logic               accept;
   logic [15:0]        rx_vec;
   logic               rx_in_range;
   logic               tbl_in_range;
   logic [IdxW-1:0]    rx_idx;
   logic [IdxW-1:0]    tbl_idx;
   logic [VECTOR_COUNT-1:0] eligible;
   logic               found;
   logic [IdxW-1:0]    win_idx;

   // memory ports
   logic                        ram_wr_en;
   logic                        ram_rd_en;
   logic [IdxW-1:0]             ram_rd_addr;
   logic [mtpr_pkg::ENTRY_W-1:0] ram_wr_data;
   logic [mtpr_pkg::ENTRY_W-1:0] ram_rd_data;

   assign mode         = mtpr_pkg::mode_type'(req_mode);
   assign accept       = start && !busy;
   assign busy         = stage_ff || reset;
   assign rx_vec       = req_write_data[15:0] & mtpr_pkg::RX_INDEX_MASK;
   assign rx_in_range  = {16'd0, rx_vec} < 32'(VECTOR_COUNT);
   assign tbl_in_range = {24'd0, req_entry_index} < 32'(VECTOR_COUNT);
   assign rx_idx       = rx_vec[IdxW-1:0];
   assign tbl_idx      = req_entry_index[IdxW-1:0];

   // vectors allowed to signal right now
   assign eligible = (req_enable_level && !req_global_mask_level)
                   ? (pending_ff & ~mask_ff & addr_nz_ff) : '0;

   mtpr_pick #(
      .VECTOR_COUNT(VECTOR_COUNT)
   ) u_pick (
      .eligible(eligible),
      .found   (found),
      .index   (win_idx)
   );

   // entry memory: address over data
   assign ram_wr_en   = accept && (mode == mtpr_pkg::MODE_TBL_WRITE) && tbl_in_range;
   assign ram_wr_data = {req_entry_address, req_entry_data};
   assign ram_rd_en   = accept && ((mode == mtpr_pkg::MODE_TBL_READ)
                                   || (mode == mtpr_pkg::MODE_SCAN));
   assign ram_rd_addr = (mode == mtpr_pkg::MODE_SCAN) ? win_idx : tbl_idx;

   mtpr_ram #(
      .WIDTH(mtpr_pkg::ENTRY_W),
      .DEPTH(VECTOR_COUNT)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(tbl_idx),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // next state of flags, pending bits and response stage
   always_comb begin
      written_in     = written_ff;
      mask_in        = mask_ff;
      addr_nz_in     = addr_nz_ff;
      pending_in     = pending_ff;
      tbl_read_in    = tbl_read_ff;
      entry_valid_in = entry_valid_ff;
      mask_out_in    = mask_out_ff;
      bus_error_in   = bus_error_ff;
      issued_in      = issued_ff;
      vector_in      = vector_ff;
      if (accept) begin
         tbl_read_in    = 1'b0;
         entry_valid_in = 1'b0;
         mask_out_in    = 1'b0;
         bus_error_in   = 1'b0;
         issued_in      = 1'b0;
         vector_in      = '0;
         case (mode)
            mtpr_pkg::MODE_RX_WRITE: begin
               if (req_bus_offset != '0) begin
                  bus_error_in = 1'b1;
               end else if (rx_in_range) begin
                  pending_in[rx_idx] = 1'b1;
               end
            end
            mtpr_pkg::MODE_TBL_WRITE: begin
               if (tbl_in_range) begin
                  written_in[tbl_idx] = 1'b1;
                  mask_in[tbl_idx]    = req_entry_mask;
                  addr_nz_in[tbl_idx] = req_entry_address != 64'd0;
               end
            end
            mtpr_pkg::MODE_TBL_READ: begin
               tbl_read_in = 1'b1;
               if (tbl_in_range) begin
                  entry_valid_in = written_ff[tbl_idx];
                  mask_out_in    = mask_ff[tbl_idx];
               end else begin
                  mask_out_in = 1'b1;
               end
            end
            mtpr_pkg::MODE_SCAN: begin
               if (found) begin
                  issued_in = 1'b1;
                  vector_in = win_idx;
                  if (req_write_ok) begin
                     pending_in[win_idx] = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff     <= '0;
         mask_ff        <= '1;
         addr_nz_ff     <= '0;
         pending_ff     <= '0;
         stage_ff       <= 1'b0;
         tbl_read_ff    <= 1'b0;
         entry_valid_ff <= 1'b0;
         mask_out_ff    <= 1'b0;
         bus_error_ff   <= 1'b0;
         issued_ff      <= 1'b0;
         vector_ff      <= '0;
      end else begin
         written_ff     <= written_in;
         mask_ff        <= mask_in;
         addr_nz_ff     <= addr_nz_in;
         pending_ff     <= pending_in;
         stage_ff       <= accept;
         tbl_read_ff    <= tbl_read_in;
         entry_valid_ff <= entry_valid_in;
         mask_out_ff    <= mask_out_in;
         bus_error_ff   <= bus_error_in;
         issued_ff      <= issued_in;
         vector_ff      <= vector_in;
      end
   end

   // response word
   assign rsp_valid             = stage_ff;
   assign rsp_read_data         = 32'd0;
   assign rsp_bus_error         = bus_error_ff;
   assign rsp_table_address_out = (tbl_read_ff && entry_valid_ff)
                                ? ram_rd_data[mtpr_pkg::ENTRY_W-1:mtpr_pkg::ENTRY_DATA_W]
                                : 64'd0;
   assign rsp_table_data_out    = (tbl_read_ff && entry_valid_ff)
                                ? ram_rd_data[mtpr_pkg::ENTRY_DATA_W-1:0] : 32'd0;
   assign rsp_table_mask_out    = tbl_read_ff && mask_out_ff;
   assign rsp_pending_out       = 32'(pending_ff);
   assign rsp_msi_issued        = issued_ff;
   assign rsp_msi_address       = issued_ff
                                ? ram_rd_data[mtpr_pkg::ENTRY_W-1:mtpr_pkg::ENTRY_DATA_W]
                                : 64'd0;
   assign rsp_msi_data          = issued_ff ? ram_rd_data[mtpr_pkg::ENTRY_DATA_W-1:0] : 32'd0;
   assign rsp_msi_vector        = 5'(vector_ff);

endmodule

>>> design/mtpr_checker.sv
// mtpr_checker: port-level assertions for msix_table_pending_relay, with its bind
// depends on mtpr_pkg and the top level's port list

module mtpr_checker #(
   parameter int VECTOR_COUNT = mtpr_pkg::VECTOR_COUNT_DEF
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic [2:0]                       req_mode,
   input logic [mtpr_pkg::BUS_OFFSET_W-1:0] req_bus_offset,
   input logic                             rsp_valid,
   input logic                             rsp_bus_error,
   input logic [31:0]                      rsp_pending_out,
   input logic                             rsp_msi_issued,
   input logic [63:0]                      rsp_msi_address,
   input logic [31:0]                      rsp_msi_data,
   input logic [4:0]                       rsp_msi_vector
);

   // every accepted word gets its result in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("accepted word gave no result in the next cycle");

   // no result without a word accepted in the cycle before
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy))
      else $error("result strobe without an accepted word");

   // a bus error comes only from a receiver write at a nonzero offset
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !((req_mode == mtpr_pkg::MODE_RX_WRITE)
                           && (req_bus_offset != '0))) |=> !rsp_bus_error)
      else $error("bus error without a bad receiver write");

   // a result that issues no message reports empty message fields
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_msi_issued) |->
         ((rsp_msi_address == 64'd0) && (rsp_msi_data == 32'd0)
          && (rsp_msi_vector == 5'd0)))
      else $error("message fields set without an issued message");

   // pending bits never reach past the last vector
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((64'(rsp_pending_out) >> VECTOR_COUNT) == 64'd0))
      else $error("pending bit beyond the vector count");

endmodule

bind msix_table_pending_relay mtpr_checker #(
   .VECTOR_COUNT(VECTOR_COUNT)
) u_mtpr_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_mode       (req_mode),
   .req_bus_offset (req_bus_offset),
   .rsp_valid      (rsp_valid),
   .rsp_bus_error  (rsp_bus_error),
   .rsp_pending_out(rsp_pending_out),
   .rsp_msi_issued (rsp_msi_issued),
   .rsp_msi_address(rsp_msi_address),
   .rsp_msi_data   (rsp_msi_data),
   .rsp_msi_vector (rsp_msi_vector)
);

>>> tb/sv/msix_table_pending_relay_test.sv
// msix_table_pending_relay_test: self-checking bench for the msi-x table and pending relay
// depends on mtpr_pkg and msix_table_pending_relay; an in-bench model predicts every
// response word from directed and random command words

module msix_table_pending_relay_test;

   localparam int NV       = mtpr_pkg::VECTOR_COUNT_DEF;
   localparam int OFFSET_W = mtpr_pkg::BUS_OFFSET_W;

   // one command word as driven on the req_ ports
   typedef struct packed {
      logic [2:0]          mode;
      logic [OFFSET_W-1:0] bus_offset;
      logic [31:0]         write_data;
      logic [7:0]          entry_index;
      logic [63:0]         entry_address;
      logic [31:0]         entry_data;
      logic                entry_mask;
      logic                enable_level;
      logic                global_mask_level;
      logic                write_ok;
   } relay_word_type;

   // one response word as seen on the rsp_ ports
   typedef struct packed {
      logic [31:0] read_data;
      logic        bus_error;
      logic [63:0] table_address;
      logic [31:0] table_data;
      logic        table_mask;
      logic [31:0] pending;
      logic        msi_issued;
      logic [63:0] msi_address;
      logic [31:0] msi_data;
      logic [4:0]  msi_vector;
   } outcome_type;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic [2:0]          req_mode;
   logic [OFFSET_W-1:0] req_bus_offset;
   logic [31:0]         req_write_data;
   logic [7:0]          req_entry_index;
   logic [63:0]         req_entry_address;
   logic [31:0]         req_entry_data;
   logic                req_entry_mask;
   logic                req_enable_level;
   logic                req_global_mask_level;
   logic                req_write_ok;
   logic        rsp_valid;
   logic [31:0] rsp_read_data;
   logic        rsp_bus_error;
   logic [63:0] rsp_table_address_out;
   logic [31:0] rsp_table_data_out;
   logic        rsp_table_mask_out;
   logic [31:0] rsp_pending_out;
   logic        rsp_msi_issued;
   logic [63:0] rsp_msi_address;
   logic [31:0] rsp_msi_data;
   logic [4:0]  rsp_msi_vector;

   // model copy of the vector table and pending array
   logic [63:0]   vec_address [NV];
   logic [31:0]   vec_data    [NV];
   logic          vec_mask    [NV];
   logic [NV-1:0] vec_pending;

   outcome_type relay_outcomes[$];
   int          fault_count  = 0;
   int          report_count = 0;
   int          rsp_count    = 0;
   bit          sender_idles = 1'b1;

   msix_table_pending_relay #(
      .VECTOR_COUNT(NV)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_mode             (req_mode),
      .req_bus_offset       (req_bus_offset),
      .req_write_data       (req_write_data),
      .req_entry_index      (req_entry_index),
      .req_entry_address    (req_entry_address),
      .req_entry_data       (req_entry_data),
      .req_entry_mask       (req_entry_mask),
      .req_enable_level     (req_enable_level),
      .req_global_mask_level(req_global_mask_level),
      .req_write_ok         (req_write_ok),
      .rsp_valid            (rsp_valid),
      .rsp_read_data        (rsp_read_data),
      .rsp_bus_error        (rsp_bus_error),
      .rsp_table_address_out(rsp_table_address_out),
      .rsp_table_data_out   (rsp_table_data_out),
      .rsp_table_mask_out   (rsp_table_mask_out),
      .rsp_pending_out      (rsp_pending_out),
      .rsp_msi_issued       (rsp_msi_issued),
      .rsp_msi_address      (rsp_msi_address),
      .rsp_msi_data         (rsp_msi_data),
      .rsp_msi_vector       (rsp_msi_vector)
   );

   // clock, period 2
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // model reset: entries zero and masked, nothing pending
   function automatic void clear_relay_state();
      for (int i = 0; i < NV; i++) begin
         vec_address[i] = '0;
         vec_data[i]    = '0;
         vec_mask[i]    = 1'b1;
      end
      vec_pending = '0;
   endfunction

   // apply one command word to the model and return its response word
   function automatic outcome_type relay_outcome(relay_word_type w);
      outcome_type o;
      logic [15:0] rx_index;
      bit          found;
      o        = '0;
      rx_index = w.write_data[15:0] & mtpr_pkg::RX_INDEX_MASK;
      found    = 1'b0;
      case (w.mode)
         mtpr_pkg::MODE_RX_WRITE: begin
            // only offset zero is a doorbell, the full 16-bit index is range checked
            if (w.bus_offset == '0) begin
               if (rx_index < NV) vec_pending[rx_index] = 1'b1;
            end else begin
               o.bus_error = 1'b1;
            end
         end
         mtpr_pkg::MODE_RX_READ: o.read_data = '0;
         mtpr_pkg::MODE_TBL_WRITE: begin
            if (w.entry_index < NV) begin
               vec_address[w.entry_index] = w.entry_address;
               vec_data[w.entry_index]    = w.entry_data;
               vec_mask[w.entry_index]    = w.entry_mask;
            end
         end
         mtpr_pkg::MODE_TBL_READ: begin
            if (w.entry_index < NV) begin
               o.table_address = vec_address[w.entry_index];
               o.table_data    = vec_data[w.entry_index];
               o.table_mask    = vec_mask[w.entry_index];
            end else begin
               o.table_mask = 1'b1;
            end
         end
         mtpr_pkg::MODE_SCAN: begin
            // lowest vector that is enabled, unmasked, pending and has an address
            for (int i = 0; i < NV; i++) begin
               if (!found && w.enable_level && !w.global_mask_level && !vec_mask[i]
                   && vec_pending[i] && vec_address[i] != '0) begin
                  found         = 1'b1;
                  o.msi_issued  = 1'b1;
                  o.msi_address = vec_address[i];
                  o.msi_data    = vec_data[i];
                  o.msi_vector  = 5'(i);
                  if (w.write_ok) vec_pending[i] = 1'b0;
               end
            end
         end
         default: ;
      endcase
      o.pending = 32'(vec_pending);
      return o;
   endfunction

   // command words: random filler, then the fields that matter for each operation
   function automatic relay_word_type noise_word();
      relay_word_type w;
      w.mode              = 3'($urandom);
      w.bus_offset        = OFFSET_W'($urandom);
      w.write_data        = $urandom;
      w.entry_index       = 8'($urandom);
      w.entry_address     = {$urandom, $urandom};
      w.entry_data        = $urandom;
      w.entry_mask        = 1'($urandom);
      w.enable_level      = 1'($urandom);
      w.global_mask_level = 1'($urandom);
      w.write_ok          = 1'($urandom);
      return w;
   endfunction

   function automatic relay_word_type tbl_write_word(logic [7:0] idx, logic [63:0] addr,
                                                     logic [31:0] data, logic mask);
      relay_word_type w;
      w               = noise_word();
      w.mode          = mtpr_pkg::MODE_TBL_WRITE;
      w.entry_index   = idx;
      w.entry_address = addr;
      w.entry_data    = data;
      w.entry_mask    = mask;
      return w;
   endfunction

   function automatic relay_word_type tbl_read_word(logic [7:0] idx);
      relay_word_type w;
      w             = noise_word();
      w.mode        = mtpr_pkg::MODE_TBL_READ;
      w.entry_index = idx;
      return w;
   endfunction

   function automatic relay_word_type rx_write_word(logic [OFFSET_W-1:0] offset,
                                                    logic [31:0] data);
      relay_word_type w;
      w            = noise_word();
      w.mode       = mtpr_pkg::MODE_RX_WRITE;
      w.bus_offset = offset;
      w.write_data = data;
      return w;
   endfunction

   function automatic relay_word_type rx_read_word(logic [OFFSET_W-1:0] offset);
      relay_word_type w;
      w            = noise_word();
      w.mode       = mtpr_pkg::MODE_RX_READ;
      w.bus_offset = offset;
      return w;
   endfunction

   function automatic relay_word_type scan_word(logic enable, logic gmask, logic ok);
      relay_word_type w;
      w                   = noise_word();
      w.mode              = mtpr_pkg::MODE_SCAN;
      w.enable_level      = enable;
      w.global_mask_level = gmask;
      w.write_ok          = ok;
      return w;
   endfunction

   // mostly well-formed traffic that programs vectors, rings them and scans
   function automatic relay_word_type random_word();
      relay_word_type w;
      int             pick;
      logic [7:0]     idx;
      logic [15:0]    rx_index;
      pick     = $urandom_range(99);
      idx      = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(NV - 1));
      rx_index = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(NV - 1));
      if (pick < 25) begin
         w = tbl_write_word(idx, ($urandom_range(9) == 0) ? 64'd0 : {$urandom, $urandom},
                            $urandom, $urandom_range(3) == 0);
      end else if (pick < 45) begin
         w = rx_write_word(($urandom_range(7) == 0) ? OFFSET_W'($urandom) : '0,
                           {16'($urandom), rx_index});
      end else if (pick < 55) begin
         w = rx_read_word(OFFSET_W'($urandom));
      end else if (pick < 67) begin
         w = tbl_read_word(idx);
      end else if (pick < 95) begin
         w = scan_word($urandom_range(9) != 0, $urandom_range(9) == 0,
                       $urandom_range(3) != 0);
      end else begin
         w      = noise_word();
         w.mode = mtpr_pkg::MODE_SCAN + 3'($urandom_range(3, 1));
      end
      return w;
   endfunction

   // drive one word and wait for the edge that takes it; start stays high afterwards
   task automatic send_word(relay_word_type w);
      if (sender_idles && $urandom_range(99) < 16) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 16);
      end
      start                 <= 1'b1;
      req_mode              <= w.mode;
      req_bus_offset        <= w.bus_offset;
      req_write_data        <= w.write_data;
      req_entry_index       <= w.entry_index;
      req_entry_address     <= w.entry_address;
      req_entry_data        <= w.entry_data;
      req_entry_mask        <= w.entry_mask;
      req_enable_level      <= w.enable_level;
      req_global_mask_level <= w.global_mask_level;
      req_write_ok          <= w.write_ok;
      do @(posedge clock); while (busy !== 1'b0);
      relay_outcomes.push_back(relay_outcome(w));
   endtask

   function automatic string show_outcome(outcome_type o);
      return $sformatf("rd=%h err=%b ta=%h td=%h tm=%b pend=%h iss=%b ma=%h md=%h mv=%0d",
                       o.read_data, o.bus_error, o.table_address, o.table_data,
                       o.table_mask, o.pending, o.msi_issued, o.msi_address, o.msi_data,
                       o.msi_vector);
   endfunction

   // compare each response word with the oldest prediction
   always @(posedge clock) begin
      outcome_type got;
      outcome_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         got = {rsp_read_data, rsp_bus_error, rsp_table_address_out, rsp_table_data_out,
                rsp_table_mask_out, rsp_pending_out, rsp_msi_issued, rsp_msi_address,
                rsp_msi_data, rsp_msi_vector};
         if (relay_outcomes.size() == 0) begin
            fault_count++;
            report_count++;
            if (report_count <= 10)
               $display("response word %0d with no command outstanding: %s",
                        rsp_count, show_outcome(got));
         end else begin
            want = relay_outcomes.pop_front();
            if (got.read_data !== want.read_data || got.bus_error !== want.bus_error
                || got.table_address !== want.table_address
                || got.table_data !== want.table_data
                || got.table_mask !== want.table_mask || got.pending !== want.pending
                || got.msi_issued !== want.msi_issued
                || got.msi_address !== want.msi_address
                || got.msi_data !== want.msi_data || got.msi_vector !== want.msi_vector) begin
               fault_count++;
               report_count++;
               if (report_count <= 10) begin
                  $display("response word %0d mismatch", rsp_count);
                  $display("  expected %s", show_outcome(want));
                  $display("  actual   %s", show_outcome(got));
               end
            end
         end
         rsp_count++;
      end
   end

   // reads of fresh and out-of-range entries, writes in and out of range
   task automatic test_table_access();
      send_word(tbl_read_word(8'd0));
      send_word(tbl_read_word(8'd255));
      send_word(tbl_write_word(8'd0, '1, '1, 1'b0));
      send_word(tbl_write_word(8'(NV - 1), 64'd1, 32'd0, 1'b0));
      send_word(tbl_write_word(8'd3, 64'd0, '1, 1'b0));
      send_word(tbl_write_word(8'(NV), '1, '1, 1'b0));
      send_word(tbl_read_word(8'(NV)));
      send_word(tbl_read_word(8'd0));
   endtask

   // doorbells at offset zero, out-of-range indexes, bad offsets and reads
   task automatic test_receiver_port();
      send_word(rx_write_word('0, 32'hFFFF_0000));
      send_word(rx_write_word('0, 32'(NV - 1)));
      send_word(rx_write_word('0, 32'd3));
      send_word(rx_write_word('0, 32'(NV)));
      send_word(rx_write_word('0, 32'h0000_FFFF));
      send_word(rx_write_word('1, 32'd1));
      send_word(rx_read_word('1));
      send_word(rx_read_word('0));
   endtask

   // disabled, globally masked, refused, accepted and empty scans
   task automatic test_scan();
      send_word(scan_word(1'b0, 1'b0, 1'b1));
      send_word(scan_word(1'b1, 1'b1, 1'b1));
      send_word(scan_word(1'b1, 1'b0, 1'b0));
      send_word(scan_word(1'b1, 1'b0, 1'b1));
      send_word(scan_word(1'b1, 1'b0, 1'b1));
      send_word(scan_word(1'b1, 1'b0, 1'b1));
   endtask

   // codes above the scan change nothing
   task automatic test_undefined_modes();
      relay_word_type w;
      for (int k = 1; k <= 3; k++) begin
         w      = noise_word();
         w.mode = mtpr_pkg::MODE_SCAN + 3'(k);
         send_word(w);
      end
   endtask

   // random traffic with a long run of back-to-back words in the middle
   task automatic test_random_traffic(int count);
      for (int n = 0; n < count; n++) begin
         sender_idles = !(n >= count / 3 && n < count / 3 + 300);
         send_word(random_word());
      end
      sender_idles = 1'b1;
   endtask

   // run limit
   initial begin
      #200000;
      $display("FAIL");
      $finish;
   end

   // main sequence
   initial begin
      int waited;
      reset                 = 1'b1;
      start                 = 1'b0;
      req_mode              = '0;
      req_bus_offset        = '0;
      req_write_data        = '0;
      req_entry_index       = '0;
      req_entry_address     = '0;
      req_entry_data        = '0;
      req_entry_mask        = 1'b0;
      req_enable_level      = 1'b0;
      req_global_mask_level = 1'b0;
      req_write_ok          = 1'b0;
      clear_relay_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_table_access();
      test_receiver_port();
      test_scan();
      test_undefined_modes();
      test_random_traffic(1625);
      start <= 1'b0;

      // drain the last responses, then watch for strays
      waited = 0;
      while (relay_outcomes.size() != 0 && waited < 100) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      if (relay_outcomes.size() != 0) begin
         fault_count++;
         $display("%0d response words never arrived", relay_outcomes.size());
      end
      if (fault_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

>>> msix_table_pending_relay.f
design/mtpr_pkg.sv
design/mtpr_ram.sv
design/mtpr_pick.sv
design/msix_table_pending_relay.sv
design/mtpr_checker.sv
tb/sv/msix_table_pending_relay_test.sv
